FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the interpolator unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold on every clock edge outside reset
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

FILE: hdl/pdi_pkg.sv
// ----------------------------------------------------------------------------
// pdi_pkg
// Types and constants of the polyline distance interpolator.
// ----------------------------------------------------------------------------
package pdi_pkg;

	localparam int DATA_W         = 32;
	localparam int PCNT_W         = 9;
	localparam int FRAC_W         = 16;
	localparam int PADDR_W        = 3;
	localparam int MAX_POINTS_DEF = 256;

	// register reset values
	localparam logic [DATA_W-1:0] SPEED_RESET = 32'd6554;  // 0.1 in Q16.16
	localparam logic [PCNT_W-1:0] PCNT_RESET  = 9'd3;

	// unity fraction, Q1.16
	localparam logic [FRAC_W:0] Q_ONE = 17'h10000;

	// command opcodes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// register select, paddr[2]
	localparam logic REG_SPEED = 1'b0;
	localparam logic REG_PCNT  = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [7:0]         load_index;
		logic signed [31:0] load_x;
		logic signed [31:0] load_y;
		logic signed [31:0] load_z;
		logic [31:0]        load_path_distance;
	} pdi_cmd_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] look_x;
		logic signed [31:0] look_y;
		logic signed [31:0] look_z;
		logic [7:0]         segment_index;
	} pdi_rsp_t;

	// one route table word: waypoint and cumulative distance
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [31:0]        d;
	} pdi_point_t;

endpackage

FILE: hdl/polyline_distance_interpolator_unit.sv
// ----------------------------------------------------------------------------
// polyline_distance_interpolator_unit
// Moves a runner along a 3D polyline by travelled distance.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat on cmd is taken when start is high and busy is low.
//   A load beat writes one waypoint into the route RAM and does not raise busy;
//   it gives no result. A tick beat adds speed_per_tick to the travelled distance,
//   wraps at the end of the route, walks to the segment that holds the distance
//   and returns position, look-at point and segment index on rsp, marked by a
//   one-cycle done strobe. busy stays high until that strobe.
//   Tick sequence: the walk reads the route RAM, then compares, for each segment
//   advanced, and skips the compare on the last segment; the divider runs only
//   when the fraction is neither 0 nor 1.
//   The fraction comes from a 16-step restoring divider; the six coordinates
//   share one 18x33 multiplier.
//   Configuration: APB port, speed_per_tick at 0x0, point_count at 0x4. Write
//   only while busy is low.
//   Reset clears travelled distance and segment and restores the registers;
//   the route RAM is not cleared and must be loaded before ticks use it.
//   The receiver cannot stall: each result is valid for the done cycle only.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module polyline_distance_interpolator_unit
	import pdi_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               start,
	output logic               busy,
	input  pdi_cmd_t           cmd,
	// result channel
	output logic               done,
	output pdi_rsp_t           rsp,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	localparam int AW   = $clog2(MAX_POINTS);
	localparam int CNTW = $clog2(MAX_POINTS + 1);
	localparam int NW   = (CNTW > PCNT_W) ? CNTW : PCNT_W;
	localparam int PW   = 2 * DATA_W + 2;            // product of 18 x 33 bits
	localparam int RW   = $bits(pdi_point_t);
	localparam logic [3:0] DIV_LAST = 4'(FRAC_W - 1);
	localparam logic [2:0] LANE_LAST = 3'd5;

	typedef enum logic [11:0] {
		S_IDLE     = 12'b0000_0000_0001,
		S_WRAP_RD  = 12'b0000_0000_0010,
		S_WRAP_CHK = 12'b0000_0000_0100,
		S_WALK_RD  = 12'b0000_0000_1000,
		S_WALK_CHK = 12'b0000_0001_0000,
		S_P0_RD    = 12'b0000_0010_0000,
		S_P1_RD    = 12'b0000_0100_0000,
		S_P2_RD    = 12'b0000_1000_0000,
		S_FRAC     = 12'b0001_0000_0000,
		S_DIV      = 12'b0010_0000_0000,
		S_MUL      = 12'b0100_0000_0000,
		S_ADD      = 12'b1000_0000_0000
	} state_t;

	state_t             state_q;
	logic [DATA_W-1:0]  speed_q;
	logic [PCNT_W-1:0]  pcnt_q;
	logic [DATA_W-1:0]  trav_q;
	logic [AW-1:0]      seg_q;
	pdi_point_t         p0_q, p1_q, p2_q;
	logic [DATA_W:0]    rem_q;
	logic [DATA_W-1:0]  div_q;
	logic [FRAC_W-1:0]  quo_q;
	logic [3:0]         bit_q;
	logic [FRAC_W:0]    frac_q;
	logic [2:0]         lane_q;
	logic signed [PW-1:0] prod_q;
	logic signed [DATA_W-1:0] base_q;
	pdi_rsp_t           res_q;
	logic               done_q;

	logic               cmd_acc;
	logic               cfg_wr;
	logic [NW-1:0]      pc_ext, n_eff, last, seg_ext;
	logic [DATA_W:0]    trav_sum;
	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_raddr;
	pdi_point_t         ram_wdata, ram_rdata;
	logic [RW-1:0]      ram_rbits;
	logic [DATA_W:0]    rem_shift;
	logic               qbit;
	logic signed [DATA_W-1:0] lerp_a, lerp_b;
	logic signed [DATA_W:0]   lerp_diff;
	logic signed [PW-1:0]     lerp_prod, lerp_sum;
	logic [DATA_W-1:0]        lerp_val;

	assign cmd_acc = start && !busy;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign rsp     = res_q;
	assign pready  = 1'b1;

	// register read back
	always_comb begin
		unique case (paddr[2])
			REG_SPEED: prdata = speed_q;
			REG_PCNT:  prdata = DATA_W'(pcnt_q);
			default:   prdata = '0;
		endcase
	end

	// effective point count, clamped to [3, MAX_POINTS]
	always_comb begin
		pc_ext = NW'(pcnt_q);
		if (pc_ext < NW'(3)) begin
			n_eff = NW'(3);
		end else if (pc_ext > NW'(MAX_POINTS)) begin
			n_eff = NW'(MAX_POINTS);
		end else begin
			n_eff = pc_ext;
		end
		last    = n_eff - NW'(3);
		seg_ext = NW'(seg_q);
	end

	assign trav_sum = {1'b0, trav_q} + {1'b0, speed_q};

	// route RAM: loads write, the sequencer reads
	assign ram_we = cmd_acc && (cmd.opcode == OP_LOAD)
		&& (32'(cmd.load_index) < 32'(MAX_POINTS));
	assign ram_wdata = '{x: cmd.load_x, y: cmd.load_y, z: cmd.load_z,
		d: cmd.load_path_distance};
	assign ram_rdata = pdi_point_t'(ram_rbits);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_WRAP_RD: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(n_eff - NW'(2));
			end
			S_WALK_RD: begin
				ram_re    = (seg_ext < last);
				ram_raddr = seg_q + AW'(1);
			end
			S_P0_RD: begin
				ram_re    = 1'b1;
				ram_raddr = seg_q;
			end
			S_P1_RD: begin
				ram_re    = 1'b1;
				ram_raddr = seg_q + AW'(1);
			end
			S_P2_RD: begin
				ram_re    = 1'b1;
				ram_raddr = seg_q + AW'(2);
			end
			default: begin
				ram_re    = 1'b0;
				ram_raddr = '0;
			end
		endcase
	end

	pdi_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_POINTS)
	) u_route_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(cmd.load_index)),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rbits)
	);

	// one restoring divide step
	always_comb begin
		rem_shift = {rem_q[DATA_W-1:0], 1'b0};
		qbit      = (rem_shift >= {1'b0, div_q});
	end

	// shared lerp unit: operand select, multiply and add
	always_comb begin
		unique case (lane_q)
			3'd0: begin lerp_a = p0_q.x; lerp_b = p1_q.x; end
			3'd1: begin lerp_a = p0_q.y; lerp_b = p1_q.y; end
			3'd2: begin lerp_a = p0_q.z; lerp_b = p1_q.z; end
			3'd3: begin lerp_a = p1_q.x; lerp_b = p2_q.x; end
			3'd4: begin lerp_a = p1_q.y; lerp_b = p2_q.y; end
			3'd5: begin lerp_a = p1_q.z; lerp_b = p2_q.z; end
			default: begin lerp_a = p0_q.x; lerp_b = p1_q.x; end
		endcase
		lerp_diff = $signed({lerp_b[DATA_W-1], lerp_b}) - $signed({lerp_a[DATA_W-1], lerp_a});
		lerp_prod = PW'($signed({1'b0, frac_q}) * lerp_diff);
		// floor toward minus infinity via arithmetic shift
		lerp_sum  = PW'(base_q) + (prod_q >>> FRAC_W);
		lerp_val  = lerp_sum[DATA_W-1:0];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= SPEED_RESET;
			pcnt_q  <= PCNT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_SPEED: speed_q <= pwdata;
				REG_PCNT:  pcnt_q  <= pwdata[PCNT_W-1:0];
				default:   speed_q <= speed_q;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			trav_q  <= '0;
			seg_q   <= '0;
			bit_q   <= '0;
			lane_q  <= '0;
			frac_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc && (cmd.opcode == OP_TICK)) begin
						// saturating advance, then clamp the segment to the route
						trav_q <= trav_sum[DATA_W] ? '1 : trav_sum[DATA_W-1:0];
						if (seg_ext > last) begin
							seg_q <= AW'(last);
						end
						state_q <= S_WRAP_RD;
					end
				end
				S_WRAP_RD: state_q <= S_WRAP_CHK;
				S_WRAP_CHK: begin
					// past the second-to-last waypoint: back to the start
					if ((seg_q != '0) && (trav_q > ram_rdata.d)) begin
						trav_q <= '0;
						seg_q  <= '0;
					end
					state_q <= S_WALK_RD;
				end
				S_WALK_RD: begin
					state_q <= (seg_ext < last) ? S_WALK_CHK : S_P0_RD;
				end
				S_WALK_CHK: begin
					if (trav_q > ram_rdata.d) begin
						seg_q   <= seg_q + AW'(1);
						state_q <= S_WALK_RD;
					end else begin
						state_q <= S_P0_RD;
					end
				end
				S_P0_RD: state_q <= S_P1_RD;
				S_P1_RD: state_q <= S_P2_RD;
				S_P2_RD: state_q <= S_FRAC;
				S_FRAC: begin
					lane_q <= '0;
					bit_q  <= '0;
					if ((p1_q.d <= p0_q.d) || (trav_q <= p0_q.d)) begin
						frac_q  <= '0;
						state_q <= S_MUL;
					end else if (trav_q >= p1_q.d) begin
						frac_q  <= Q_ONE;
						state_q <= S_MUL;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					bit_q <= bit_q + 4'd1;
					if (bit_q == DIV_LAST) begin
						frac_q  <= {1'b0, quo_q[FRAC_W-2:0], qbit};
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_ADD;
				S_ADD: begin
					if (lane_q == LANE_LAST) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						lane_q  <= lane_q + 3'd1;
						state_q <= S_MUL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// waypoint capture, in the state after each read
		if (state_q == S_P1_RD) begin
			p0_q <= ram_rdata;
		end
		if (state_q == S_P2_RD) begin
			p1_q <= ram_rdata;
		end
		if (state_q == S_FRAC) begin
			p2_q  <= ram_rdata;
			rem_q <= {1'b0, trav_q - p0_q.d};
			div_q <= p1_q.d - p0_q.d;
			quo_q <= '0;
		end
		// divider: remainder stays below the divisor
		if (state_q == S_DIV) begin
			rem_q <= qbit ? (rem_shift - {1'b0, div_q}) : rem_shift;
			quo_q <= {quo_q[FRAC_W-2:0], qbit};
		end
		if (state_q == S_MUL) begin
			prod_q <= lerp_prod;
			base_q <= lerp_a;
		end
		// result assembly
		if (state_q == S_ADD) begin
			unique case (lane_q)
				3'd0: res_q.pos_x  <= lerp_val;
				3'd1: res_q.pos_y  <= lerp_val;
				3'd2: res_q.pos_z  <= lerp_val;
				3'd3: res_q.look_x <= lerp_val;
				3'd4: res_q.look_y <= lerp_val;
				3'd5: begin
					res_q.look_z        <= lerp_val;
					res_q.segment_index <= 8'(seg_q);
				end
				default: res_q.pos_x <= res_q.pos_x;
			endcase
		end
	end

	// checks
	`ASSERT_PROP(a_load_single_cycle, clk, arst_n, (cmd_acc && cmd.opcode == OP_LOAD) |=> !busy, "load beat did not finish in one cycle")
	`ASSERT_PROP(a_done_after_last_lerp, clk, arst_n, done |-> $past(state_q == S_ADD && lane_q == LANE_LAST), "result strobe without finished interpolation")
	`ASSERT_PROP(a_seg_in_route, clk, arst_n, done |-> (seg_ext <= last), "segment beyond last valid segment")
	`ASSERT_PROP(a_div_rem_bound, clk, arst_n, (state_q == S_DIV) |-> (rem_q < {1'b0, div_q}), "divider remainder not below divisor")
	`ASSERT_NEVER(a_frac_bound, clk, arst_n, frac_q > Q_ONE, "fraction above one")

endmodule

FILE: hdl/pdi_ram.sv
// ----------------------------------------------------------------------------
// pdi_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pdi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the polyline distance interpolator. Command beats
// (waypoint loads and ticks) go in through the start/busy handshake with
// random gaps. A local model of the runner (travelled distance, segment,
// route table) predicts every tick result. A monitor compares each done beat
// with the oldest prediction. The APB registers are written and read back
// between phases, once the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
	import pdi_pkg::*;

	localparam int ROUTE_DEPTH  = MAX_POINTS_DEF;
	localparam int RANDOM_ITEMS = 500;
	localparam int DRAIN_CYCLES = 64;

	logic               clk;
	logic               arst_n  = 1'b0;
	logic               start   = 1'b0;
	logic               busy;
	pdi_cmd_t           cmd     = '0;
	logic               done;
	pdi_rsp_t           rsp;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [DATA_W-1:0]  pwdata  = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	// model of the runner: route table, registers, position on the route
	pdi_point_t  route_table [ROUTE_DEPTH];
	logic [31:0] speed_q16;
	logic [8:0]  point_count_reg;
	logic [31:0] travelled_q16;
	int unsigned runner_segment;
	pdi_rsp_t    expected_poses [$];

	int error_count = 0;
	int items_sent  = 0;
	bit steady      = 1'b0;

	polyline_distance_interpolator_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.done    (done),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit, far above the slowest legal run
	initial begin
		#(30_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

	// a + floor(frac * (b - a) / 2^16), signed Q16.16
	function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [16:0] frac);
		longint sa;
		longint sb;
		longint scaled;
		sa     = longint'(signed'(a));
		sb     = longint'(signed'(b));
		scaled = longint'(frac) * (sb - sa);
		return 32'(sa + (scaled >>> 16));
	endfunction

	// one tick: advance, wrap, walk, interpolate
	function automatic pdi_rsp_t advance_runner();
		int unsigned n;
		int unsigned last;
		int unsigned s;
		logic [31:0] d0;
		logic [31:0] d1;
		logic [47:0] quotient;
		logic [16:0] frac;
		pdi_rsp_t    r;
		n = (point_count_reg < 3) ? 3 :
			(point_count_reg > ROUTE_DEPTH) ? ROUTE_DEPTH : point_count_reg;
		last = n - 3;
		if (travelled_q16 > 32'hFFFF_FFFF - speed_q16)
			travelled_q16 = 32'hFFFF_FFFF;
		else
			travelled_q16 = travelled_q16 + speed_q16;
		if (runner_segment > last)
			runner_segment = last;
		if (runner_segment > 0 && travelled_q16 > route_table[n - 2].d) begin
			travelled_q16  = '0;
			runner_segment = 0;
		end
		while (runner_segment < last && travelled_q16 > route_table[runner_segment + 1].d)
			runner_segment++;
		s  = runner_segment;
		d0 = route_table[s].d;
		d1 = route_table[s + 1].d;
		if (d1 <= d0 || travelled_q16 <= d0) begin
			frac = '0;
		end else if (travelled_q16 >= d1) begin
			frac = Q_ONE;
		end else begin
			quotient = {travelled_q16 - d0, 16'h0000} / {16'h0000, d1 - d0};
			frac     = quotient[16:0];
		end
		r.pos_x         = blend(route_table[s].x, route_table[s + 1].x, frac);
		r.pos_y         = blend(route_table[s].y, route_table[s + 1].y, frac);
		r.pos_z         = blend(route_table[s].z, route_table[s + 1].z, frac);
		r.look_x        = blend(route_table[s + 1].x, route_table[s + 2].x, frac);
		r.look_y        = blend(route_table[s + 1].y, route_table[s + 2].y, frac);
		r.look_z        = blend(route_table[s + 1].z, route_table[s + 2].z, frac);
		r.segment_index = 8'(s);
		return r;
	endfunction

	function automatic pdi_cmd_t load_cmd(logic [7:0] idx, logic [31:0] x, logic [31:0] y,
			logic [31:0] z, logic [31:0] d);
		pdi_cmd_t c;
		c.opcode             = OP_LOAD;
		c.load_index         = idx;
		c.load_x             = x;
		c.load_y             = y;
		c.load_z             = z;
		c.load_path_distance = d;
		return c;
	endfunction

	// tick with junk in the unused load fields
	function automatic pdi_cmd_t tick_cmd();
		pdi_cmd_t c;
		c.opcode             = OP_TICK;
		c.load_index         = 8'($urandom);
		c.load_x             = $urandom;
		c.load_y             = $urandom;
		c.load_z             = $urandom;
		c.load_path_distance = $urandom;
		return c;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	// result monitor: every done beat against the oldest prediction
	always @(posedge clk) begin : result_check
		pdi_rsp_t want;
		if (arst_n && done) begin
			if (expected_poses.size() == 0) begin
				error_count++;
				$display("%0t: result with none expected, expected nothing, actual %h",
					$time, rsp);
			end else begin
				want = expected_poses.pop_front();
				check_field("pos_x", want.pos_x, rsp.pos_x);
				check_field("pos_y", want.pos_y, rsp.pos_y);
				check_field("pos_z", want.pos_z, rsp.pos_z);
				check_field("look_x", want.look_x, rsp.look_x);
				check_field("look_y", want.look_y, rsp.look_y);
				check_field("look_z", want.look_z, rsp.look_z);
				check_field("segment_index", 32'(want.segment_index), 32'(rsp.segment_index));
			end
		end
	end

	// one command beat; start stays high when the next beat follows at once
	task automatic send_cmd(input pdi_cmd_t item);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= item;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
		if (item.opcode == OP_LOAD)
			route_table[item.load_index] = {item.load_x, item.load_y, item.load_z,
				item.load_path_distance};
		else
			expected_poses.push_back(advance_runner());
	endtask

	// stop issuing and let outstanding ticks and loads finish
	task automatic settle();
		start <= 1'b0;
		while (expected_poses.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write followed by a read-back of the same register
	task automatic write_register(input logic sel, input logic [31:0] value);
		logic [31:0] readback_want;
		settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (sel == REG_SPEED)
			speed_q16 = value;
		else
			point_count_reg = value[8:0];
		readback_want = (sel == REG_SPEED) ? value : {23'd0, value[8:0]};
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== readback_want) begin
			error_count++;
			$display("%0t: register %0d read-back mismatch, expected %h, actual %h",
				$time, sel, readback_want, prdata);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// waypoints 0..npts-1 with rising distance; broken routes jump at random
	task automatic load_route(input int npts, input int unsigned step_lo,
			input int unsigned step_hi, input bit broken);
		logic [31:0] path_dist;
		path_dist = $urandom_range(0, step_hi);
		for (int i = 0; i < npts; i++) begin
			if (broken && $urandom_range(0, 2) == 0)
				path_dist = $urandom;
			send_cmd(load_cmd(8'(i), $urandom, $urandom, $urandom, path_dist));
			// now and then a zero-length segment
			if ($urandom_range(0, 15) != 0)
				path_dist = path_dist + $urandom_range(step_lo, step_hi);
		end
	endtask

	// whole table written once so any point count reads loaded entries only
	task automatic test_route_table_init();
		load_route(ROUTE_DEPTH, 32'h8000, 32'h1_8000, 1'b0);
	endtask

	// extreme coordinates and distances, mid and full fractions
	task automatic test_field_extremes();
		send_cmd(load_cmd(8'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000));
		send_cmd(load_cmd(8'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_8000));
		send_cmd(load_cmd(8'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF));
		send_cmd(load_cmd(8'd255, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF));
		repeat (6) send_cmd(tick_cmd());
	endtask

	// zero-length, reversed and not-yet-reached segments; zero speed
	task automatic test_degenerate_segments();
		send_cmd(load_cmd(8'd0, $urandom, $urandom, $urandom, 32'h0000_1000));
		send_cmd(load_cmd(8'd1, $urandom, $urandom, $urandom, 32'h0000_1000));
		send_cmd(tick_cmd());
		send_cmd(load_cmd(8'd1, $urandom, $urandom, $urandom, 32'h0000_0800));
		send_cmd(tick_cmd());
		send_cmd(load_cmd(8'd0, $urandom, $urandom, $urandom, 32'hF000_0000));
		send_cmd(load_cmd(8'd1, $urandom, $urandom, $urandom, 32'hFFFF_0000));
		send_cmd(tick_cmd());
		write_register(REG_SPEED, 32'h0000_0000);
		repeat (2) send_cmd(tick_cmd());
	endtask

	// saturating add, walk past the segment end, wrap to the start
	task automatic test_saturation_and_wrap();
		write_register(REG_PCNT, 32'd4);
		write_register(REG_SPEED, 32'hFFFF_FFFF);
		send_cmd(load_cmd(8'd0, $urandom, $urandom, $urandom, 32'h0000_0000));
		send_cmd(load_cmd(8'd1, $urandom, $urandom, $urandom, 32'h0001_0000));
		send_cmd(load_cmd(8'd2, $urandom, $urandom, $urandom, 32'h0002_0000));
		send_cmd(load_cmd(8'd3, $urandom, $urandom, $urandom, 32'h0003_0000));
		repeat (3) send_cmd(tick_cmd());
	endtask

	// point count beyond both ends; a shorter route clamps a deep segment
	task automatic test_count_clamp();
		write_register(REG_SPEED, 32'h0080_0000);
		write_register(REG_PCNT, 32'h1FF);
		repeat (4) send_cmd(tick_cmd());
		write_register(REG_PCNT, 32'd2);
		send_cmd(tick_cmd());
		write_register(REG_PCNT, 32'd257);
		send_cmd(tick_cmd());
		write_register(REG_PCNT, 32'd256);
		send_cmd(tick_cmd());
		write_register(REG_PCNT, 32'd0);
		send_cmd(tick_cmd());
		write_register(REG_PCNT, 32'd3);
		send_cmd(tick_cmd());
	endtask

	// phases: new count and speed, mostly fresh routes, then a ride of ticks
	task automatic test_random_routes();
		int unsigned count_value;
		int unsigned n_eff;
		int unsigned step_hi;
		int unsigned ticks;
		int          first_item;
		bit          broken;
		first_item = items_sent;
		while (items_sent - first_item < RANDOM_ITEMS) begin
			case ($urandom_range(0, 19))
				0:       count_value = ROUTE_DEPTH;
				1:       count_value = $urandom_range(3, ROUTE_DEPTH);
				2:       count_value = $urandom_range(0, 2);
				3:       count_value = $urandom_range(ROUTE_DEPTH + 1, 511);
				default: count_value = $urandom_range(3, 12);
			endcase
			n_eff = (count_value < 3) ? 3 :
				(count_value > ROUTE_DEPTH) ? ROUTE_DEPTH : count_value;
			step_hi = $urandom_range(1, 32'h4_0000);
			broken  = ($urandom_range(0, 4) == 0);
			steady  = ($urandom_range(0, 3) == 0);
			write_register(REG_PCNT, count_value);
			// long routes ride on the table written at start
			if (n_eff > 16)
				step_hi = 32'h1_8000;
			case ($urandom_range(0, 7))
				0:       write_register(REG_SPEED, $urandom);
				1:       write_register(REG_SPEED, 32'h0000_0000);
				default: write_register(REG_SPEED, $urandom_range(step_hi / 16 + 1, step_hi));
			endcase
			if (n_eff <= 16)
				load_route(n_eff, 0, step_hi, broken);
			ticks = $urandom_range(8, 40);
			repeat (ticks) begin
				if ($urandom_range(0, 9) == 0)
					send_cmd(load_cmd(8'($urandom), $urandom, $urandom, $urandom, $urandom));
				else
					send_cmd(tick_cmd());
			end
		end
	endtask

	initial begin
		speed_q16       = SPEED_RESET;
		point_count_reg = PCNT_RESET;
		travelled_q16   = '0;
		runner_segment  = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_route_table_init();
		test_field_extremes();
		test_degenerate_segments();
		test_saturation_and_wrap();
		test_count_clamp();
		test_random_routes();
		settle();
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
